[src/aaid_pkg.sv]
// shared types and constants for the area average image downscaler
// no dependencies
package aaid_pkg;

    localparam int CFG_W        = 12;
    localparam int CFG_IDX_W    = 2;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int PIX_W        = 24;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 64;
    localparam int BOX_W        = 11;
    localparam int LUMA_W       = 16;

    // rec.709 weights in q16
    localparam logic [15:0] LUMA_WR = 16'd13933;
    localparam logic [15:0] LUMA_WG = 16'd46871;
    localparam logic [15:0] LUMA_WB = 16'd4732;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH   = 2'd0,
        REG_IN_HEIGHT  = 2'd1,
        REG_OUT_WIDTH  = 2'd2,
        REG_OUT_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_DIVW,
        ST_DIVH,
        ST_IDLE,
        ST_PIX,
        ST_MEAN,
        ST_EMIT
    } aaid_state_t;

endpackage

[src/area_average_image_downscaler.sv]
// area average image downscaler: raster rgb pixels in, box means and luma out
// uses aaid_pkg; box sums live in one on-chip memory of two row-band banks
//
// s_axis carries one pixel per request (red, green, blue from bit 0 up).
// m_axis carries one finished box per request; tlast marks the last box of
// the frame. cfg writes a size register (index 0..3) and restarts the frame.
// A pixel is taken in the idle state, then goes through read-modify-write
// slots on the sum memory, which has one read and one write port (up to four
// box entries touched, read and write of neighbouring slots overlapped). A
// pixel that finishes a box then passes a 9-step shift-subtract divider for
// the three means, and luma is loaded with them into the output register.
// No new pixel is taken before the last one is through. After reset and
// after every cfg write the block sweeps all 2*MAX_WIDTH entries of the sum
// memory, then derives the box step sizes with two restoring divisions;
// s_axis_tready is low meanwhile. When the receiver stalls, the result
// holds in the output register while the next pixel is taken; a further
// finished box waits until it is free.
module area_average_image_downscaler #(
    parameter int MAX_WIDTH  = aaid_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = aaid_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // red_in, green_in, blue_in
    input  logic [aaid_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // box_column, box_row, red_mean, green_mean, blue_mean, luminance_q8, pad
    output logic [aaid_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aaid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aaid_pkg::CFG_W-1:0]       cfg_data
);
    import aaid_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int SWW   = $clog2(MAX_WIDTH + 1);
    localparam int SWH   = $clog2(MAX_HEIGHT + 1);
    localparam int EXW   = (SWW > CFG_W) ? SWW : CFG_W;
    localparam int EXH   = (SWH > CFG_W) ? SWH : CFG_W;
    localparam int DIVW  = (SWW > SWH) ? SWW : SWH;
    localparam int DCW   = $clog2(DIVW);
    localparam int AW    = $clog2(2 * MAX_WIDTH);
    localparam int DEPTH = 2 * MAX_WIDTH;
    localparam int CNTW  = SWW + SWH;
    localparam int SUM_W = CNTW + 8;
    localparam int MW    = 3 * SUM_W;
    localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0]  BANK1     = AW'(MAX_WIDTH);
    localparam logic [DCW-1:0] DIV_TOP   = DCW'(DIVW - 1);

    aaid_state_t state_reg, state_next;

    logic [CFG_W-1:0] in_width_reg, in_height_reg, out_width_reg, out_height_reg;
    logic             cfg_wr;

    logic [SWW-1:0] w_eff, ow_eff;
    logic [SWH-1:0] h_eff, oh_eff;

    logic [AW-1:0]   clr_addr_reg;
    logic [DCW-1:0]  div_cnt_reg;
    logic [DIVW-1:0] div_rem_reg, div_quo_reg;
    logic [DIVW-1:0] dvd, dsr, quo_next, rem_next;
    logic [DIVW:0]   trial;
    logic            div_ge;
    logic [SWW-1:0]  wq_reg, wr_reg;
    logic [SWH-1:0]  hq_reg, hr_reg;

    logic [XW-1:0]  x_reg, bx_reg;
    logic [YW-1:0]  y_reg, by_reg;
    logic           bank_reg;
    logic [SWW-1:0] cs_reg, cq_reg, cr_reg;
    logic [SWH-1:0] rs_reg, rq_reg, rr_reg;

    logic [SWW-1:0] cend, x1, bx1;
    logic [SWH-1:0] rend, y1, by1;
    logic           sc, sr, emit;
    logic [SWW:0]   csum;
    logic           cge;
    logic [SWH:0]   rsum;
    logic           rge;

    logic [PIX_W-1:0] pix_reg;
    logic [2:0]       slot_reg;
    logic [AW-1:0]    addr [4];
    logic [3:0]       act;
    logic [AW-1:0]    raddr, waddr;
    logic             we;
    logic [MW-1:0]    wdata, upd, rdata_reg;
    logic [MW-1:0]    mem [DEPTH];

    logic [CNTW-1:0]  count_reg;
    logic [SUM_W-1:0] dv_reg;
    logic [SUM_W-1:0] mrem_reg [3];
    logic [7:0]       mq_reg [3];
    logic [2:0]       sat_reg;
    logic [3:0]       mcnt_reg;
    logic [BOX_W-1:0] ocol_reg, orow_reg;
    logic             olast_reg;

    logic [7:0]  mean [3];
    logic [25:0] lum_full;
    logic        out_load;

    logic             out_valid_reg, out_last_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // effective sizes
    always_comb
    begin
        if (in_width_reg == '0)
            w_eff = SWW'(1);
        else if (EXW'(in_width_reg) > EXW'(MAX_WIDTH))
            w_eff = SWW'(MAX_WIDTH);
        else
            w_eff = SWW'(in_width_reg);
        if (in_height_reg == '0)
            h_eff = SWH'(1);
        else if (EXH'(in_height_reg) > EXH'(MAX_HEIGHT))
            h_eff = SWH'(MAX_HEIGHT);
        else
            h_eff = SWH'(in_height_reg);
        if (out_width_reg == '0)
            ow_eff = SWW'(1);
        else if (EXW'(out_width_reg) > EXW'(w_eff))
            ow_eff = w_eff;
        else
            ow_eff = SWW'(out_width_reg);
        if (out_height_reg == '0)
            oh_eff = SWH'(1);
        else if (EXH'(out_height_reg) > EXH'(h_eff))
            oh_eff = h_eff;
        else
            oh_eff = SWH'(out_height_reg);
    end

    assign cfg_ready     = 1'b1;
    assign cfg_wr        = cfg_valid & cfg_ready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg   <= CFG_W'(640);
            in_height_reg  <= CFG_W'(480);
            out_width_reg  <= CFG_W'(64);
            out_height_reg <= CFG_W'(48);
        end
        else if (cfg_wr)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IN_WIDTH:   in_width_reg   <= cfg_data;
                REG_IN_HEIGHT:  in_height_reg  <= cfg_data;
                REG_OUT_WIDTH:  out_width_reg  <= cfg_data;
                REG_OUT_HEIGHT: out_height_reg <= cfg_data;
                default:        in_width_reg   <= in_width_reg;
            endcase
        end
    end

    // restoring divider for the box step sizes
    always_comb
    begin
        dvd      = (state_reg == ST_DIVW) ? DIVW'(w_eff) : DIVW'(h_eff);
        dsr      = (state_reg == ST_DIVW) ? DIVW'(ow_eff) : DIVW'(oh_eff);
        trial    = {div_rem_reg, dvd[div_cnt_reg]};
        div_ge   = (trial >= {1'b0, dsr});
        rem_next = div_ge ? DIVW'(trial - {1'b0, dsr}) : DIVW'(trial);
        quo_next = {div_quo_reg[DIVW-2:0], div_ge};
    end

    // box boundaries
    always_comb
    begin
        cend = cq_reg + SWW'(cr_reg != '0);
        rend = rq_reg + SWH'(rr_reg != '0);
        x1   = SWW'(x_reg) + SWW'(1);
        y1   = SWH'(y_reg) + SWH'(1);
        bx1  = SWW'(bx_reg) + SWW'(1);
        by1  = SWH'(by_reg) + SWH'(1);
        sc   = (bx1 < ow_eff) && (cq_reg <= SWW'(x_reg));
        sr   = (by1 < oh_eff) && (rq_reg <= SWH'(y_reg));
        emit = (x1 == cend) && (y1 == rend);
        csum = {1'b0, cr_reg} + {1'b0, wr_reg};
        cge  = (csum >= {1'b0, ow_eff});
        rsum = {1'b0, rr_reg} + {1'b0, hr_reg};
        rge  = (rsum >= {1'b0, oh_eff});
    end

    // memory slots of one pixel
    always_comb
    begin
        addr[0] = bank_reg ? BANK1 + AW'(bx_reg) : AW'(bx_reg);
        addr[1] = sc ? addr[0] + AW'(1) : addr[0];
        addr[2] = sr ? (bank_reg ? AW'(bx_reg) : BANK1 + AW'(bx_reg)) : addr[0];
        addr[3] = (sc && sr) ? addr[2] + AW'(1) : addr[0];
        act     = {sc & sr, sr, sc, 1'b1};
        raddr   = addr[slot_reg[1:0]];
        for (int c = 0; c < 3; c++)
        begin
            upd[SUM_W*c +: SUM_W] = rdata_reg[SUM_W*c +: SUM_W]
                                  + SUM_W'(pix_reg[8*c +: 8]);
        end
        waddr = clr_addr_reg;
        wdata = '0;
        we    = 1'b0;
        if (state_reg == ST_CLEAR)
            we = 1'b1;
        else if (state_reg == ST_PIX && slot_reg != 3'd0)
        begin
            waddr = addr[2'(slot_reg - 3'd1)];
            we    = act[2'(slot_reg - 3'd1)];
            wdata = (slot_reg == 3'd1 && emit) ? '0 : upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_CLEAR:
                if (clr_addr_reg == LAST_ADDR)
                    state_next = ST_DIVW;
            ST_DIVW:
                if (div_cnt_reg == '0)
                    state_next = ST_DIVH;
            ST_DIVH:
                if (div_cnt_reg == '0)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (s_axis_tvalid)
                    state_next = ST_PIX;
            ST_PIX:
                if (slot_reg == 3'd4)
                    state_next = emit ? ST_MEAN : ST_IDLE;
            ST_MEAN:
                if (mcnt_reg == 4'd0)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_CLEAR;
        endcase
        if (cfg_wr)
            state_next = ST_CLEAR;
    end

    // sweep, size division, position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            div_cnt_reg  <= DIV_TOP;
            div_rem_reg  <= '0;
            div_quo_reg  <= '0;
            wq_reg       <= '0;
            wr_reg       <= '0;
            hq_reg       <= '0;
            hr_reg       <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            bx_reg       <= '0;
            by_reg       <= '0;
            bank_reg     <= 1'b0;
            cs_reg       <= '0;
            cq_reg       <= '0;
            cr_reg       <= '0;
            rs_reg       <= '0;
            rq_reg       <= '0;
            rr_reg       <= '0;
            slot_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            clr_addr_reg <= '0;
            div_cnt_reg  <= DIV_TOP;
            div_rem_reg  <= '0;
            div_quo_reg  <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            bx_reg       <= '0;
            by_reg       <= '0;
            bank_reg     <= 1'b0;
            slot_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                ST_DIVW, ST_DIVH:
                begin
                    if (div_cnt_reg == '0)
                    begin
                        div_cnt_reg <= DIV_TOP;
                        div_rem_reg <= '0;
                        div_quo_reg <= '0;
                        if (state_reg == ST_DIVW)
                        begin
                            wq_reg <= SWW'(quo_next);
                            wr_reg <= SWW'(rem_next);
                        end
                        else
                        begin
                            hq_reg <= SWH'(quo_next);
                            hr_reg <= SWH'(rem_next);
                            cs_reg <= '0;
                            cq_reg <= wq_reg;
                            cr_reg <= wr_reg;
                            rs_reg <= '0;
                            rq_reg <= SWH'(quo_next);
                            rr_reg <= SWH'(rem_next);
                        end
                    end
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg - DCW'(1);
                        div_rem_reg <= rem_next;
                        div_quo_reg <= quo_next;
                    end
                end
                ST_PIX:
                begin
                    slot_reg <= (slot_reg == 3'd4) ? 3'd0 : slot_reg + 3'd1;
                    if (slot_reg == 3'd4)
                    begin
                        if (x1 >= w_eff)
                        begin
                            x_reg  <= '0;
                            bx_reg <= '0;
                            cs_reg <= '0;
                            cq_reg <= wq_reg;
                            cr_reg <= wr_reg;
                            if (y1 >= h_eff)
                            begin
                                y_reg    <= '0;
                                by_reg   <= '0;
                                bank_reg <= 1'b0;
                                rs_reg   <= '0;
                                rq_reg   <= hq_reg;
                                rr_reg   <= hr_reg;
                            end
                            else
                            begin
                                y_reg <= YW'(y1);
                                if (y1 >= rend && by1 < oh_eff)
                                begin
                                    by_reg   <= YW'(by1);
                                    bank_reg <= ~bank_reg;
                                    rs_reg   <= rq_reg;
                                    rq_reg   <= rq_reg + hq_reg + SWH'(rge);
                                    rr_reg   <= rge ? SWH'(rsum - {1'b0, oh_eff})
                                                    : SWH'(rsum);
                                end
                            end
                        end
                        else
                        begin
                            x_reg <= XW'(x1);
                            if (x1 >= cend && bx1 < ow_eff)
                            begin
                                bx_reg <= XW'(bx1);
                                cs_reg <= cq_reg;
                                cq_reg <= cq_reg + wq_reg + SWW'(cge);
                                cr_reg <= cge ? SWW'(csum - {1'b0, ow_eff})
                                              : SWW'(csum);
                            end
                        end
                    end
                end
                default:
                    slot_reg <= '0;
            endcase
        end
    end

    // pixel capture and mean divider
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
            pix_reg <= s_axis_tdata[PIX_W-1:0];
        if (state_reg == ST_PIX && slot_reg == 3'd0)
            count_reg <= {{SWH{1'b0}}, SWW'(cend - cs_reg)}
                       * {{SWW{1'b0}}, SWH'(rend - rs_reg)};
        if (state_reg == ST_PIX && slot_reg == 3'd1)
        begin
            for (int c = 0; c < 3; c++)
                mrem_reg[c] <= upd[SUM_W*c +: SUM_W];
        end
        if (state_reg == ST_PIX && slot_reg == 3'd4)
        begin
            dv_reg    <= {count_reg, 8'd0};
            ocol_reg  <= BOX_W'(bx_reg);
            orow_reg  <= BOX_W'(by_reg);
            olast_reg <= (bx1 == ow_eff) && (by1 == oh_eff);
        end
        if (state_reg == ST_MEAN)
        begin
            dv_reg <= dv_reg >> 1;
            for (int c = 0; c < 3; c++)
            begin
                if (mcnt_reg == 4'd8)
                begin
                    sat_reg[c] <= (mrem_reg[c] >= dv_reg);
                    mq_reg[c]  <= '0;
                end
                else if (mrem_reg[c] >= dv_reg)
                begin
                    mrem_reg[c] <= mrem_reg[c] - dv_reg;
                    mq_reg[c]   <= {mq_reg[c][6:0], 1'b1};
                end
                else
                    mq_reg[c] <= {mq_reg[c][6:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mcnt_reg <= 4'd8;
        else if (state_reg == ST_MEAN)
            mcnt_reg <= (mcnt_reg == 4'd0) ? 4'd8 : mcnt_reg - 4'd1;
        else
            mcnt_reg <= 4'd8;
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            mean[c] = sat_reg[c] ? 8'hFF : mq_reg[c];
        lum_full = 26'(LUMA_WR * mean[0]) + 26'(LUMA_WG * mean[1])
                 + 26'(LUMA_WB * mean[2]);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {2'b00, lum_full[23:8], mean[2], mean[1], mean[0],
                             orow_reg, ocol_reg};
            out_last_reg <= olast_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (SWW'(x_reg) < w_eff) && (SWH'(y_reg) < h_eff))
        else $error("pixel position outside frame");

    a_box_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SWW'(bx_reg) < ow_eff) && (SWH'(by_reg) < oh_eff))
        else $error("box index outside output size");

    a_pixel_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !cfg_wr) |=>
            (state_reg == ST_PIX && slot_reg == 3'd0))
        else $error("accepted pixel not processed");

endmodule
